// ----- rtl/core/grid_dfs_explorer_macros.svh -----
// ---------------------------------------------------------------------------
// grid_dfs_explorer_macros.svh
// Assertion macros shared by the grid explorer checks.
// ---------------------------------------------------------------------------
`ifndef GRID_DFS_EXPLORER_MACROS_SVH
`define GRID_DFS_EXPLORER_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define GDFS_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked at every edge, reset included.
`define GDFS_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/gdfs_pkg.sv -----
// ---------------------------------------------------------------------------
// gdfs_pkg
// Grid geometry, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package gdfs_pkg;

  // COLS and ROWS are powers of two, so a cell index is {row, col}.
  localparam int ROWS   = 16;
  localparam int COLS   = 32;
  localparam int NCELLS = ROWS * COLS;

  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLS);
  localparam int CELL_W    = $clog2(NCELLS);
  localparam int CNT_W     = $clog2(NCELLS + 1);
  localparam int CFG_W     = CELL_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CELL_W-1:0] START_RESET = '0;
  localparam logic [CELL_W-1:0] GOAL_RESET  = CELL_W'(511);

  localparam logic [CFG_IDX_W-1:0] REG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL  = 1'b1;

  localparam logic [1:0] OP_WALL  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [1:0] ST_CELL  = 2'd0;
  localparam logic [1:0] ST_GOAL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] NB_RIGHT = 2'd0;
  localparam logic [1:0] NB_LEFT  = 2'd1;
  localparam logic [1:0] NB_DOWN  = 2'd2;
  localparam logic [1:0] NB_UP    = 2'd3;

  typedef struct packed {
    logic       wall_we;
    logic       clr_step;
    logic       begin_set;
    logic       pop;
    logic       capture;
    logic       emit_empty;
    logic       nb_issue;
    logic [1:0] nb_sel;
    logic       nb_eval;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic goal;
    logic clr_last;
  } sts_t;

endpackage

// ----- rtl/core/gdfs_ram.sv -----
// ---------------------------------------------------------------------------
// gdfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module gdfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/gdfs_ctrl.sv -----
// ---------------------------------------------------------------------------
// gdfs_ctrl
// Sequencer for wall writes, search start and search steps.
// ---------------------------------------------------------------------------
module gdfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    operation,
  input  gdfs_pkg::sts_t sts,
  output gdfs_pkg::cmd_t cmd
);
  import gdfs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_SET   = 6'b000100,
    S_POP   = 6'b001000,
    S_POPW  = 6'b010000,
    S_NB    = 6'b100000
  } state_t;

  localparam logic [2:0] NB_LAST = 3'd4;

  state_t     state, state_next;
  logic [2:0] nb_cnt, nb_cnt_next;

  always_comb begin
    state_next  = state;
    nb_cnt_next = nb_cnt;
    cmd         = '0;
    in_ready    = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (operation)
            OP_WALL:  cmd.wall_we = 1'b1;
            OP_BEGIN: state_next = S_CLEAR;
            OP_STEP:  state_next = S_POP;
            default:  ;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_SET;
        end
      end
      S_SET: begin
        cmd.begin_set = 1'b1;
        state_next    = S_IDLE;
      end
      S_POP: begin
        if (sts.out_free) begin
          if (sts.empty) begin
            cmd.emit_empty = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.pop    = 1'b1;
            state_next = S_POPW;
          end
        end
      end
      S_POPW: begin
        cmd.capture = 1'b1;
        nb_cnt_next = '0;
        state_next  = sts.goal ? S_IDLE : S_NB;
      end
      S_NB: begin
        cmd.nb_sel   = nb_cnt[1:0];
        cmd.nb_issue = (nb_cnt != NB_LAST);
        cmd.nb_eval  = (nb_cnt != 3'd0);
        nb_cnt_next  = nb_cnt + 3'd1;
        if (nb_cnt == NB_LAST) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      nb_cnt <= '0;
    end else begin
      state  <= state_next;
      nb_cnt <= nb_cnt_next;
    end
  end

endmodule

// ----- rtl/core/gdfs_dp.sv -----
// ---------------------------------------------------------------------------
// gdfs_dp
// Wall, seen and stack memories, stack pointer and the result register.
// ---------------------------------------------------------------------------
module gdfs_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  gdfs_pkg::cmd_t                     cmd,
  output gdfs_pkg::sts_t                     sts,
  input  logic [gdfs_pkg::ROW_W-1:0]         row,
  input  logic [gdfs_pkg::COL_W-1:0]         col,
  input  logic                               wall,
  input  logic                               cfg_we,
  input  logic [gdfs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gdfs_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [gdfs_pkg::ROW_W-1:0]         visit_row,
  output logic [gdfs_pkg::COL_W-1:0]         visit_col,
  output logic [1:0]                         status
);
  import gdfs_pkg::*;

  logic [CELL_W-1:0] start_cell, goal_cell;
  logic [CNT_W-1:0]  count;
  logic              done;
  logic [CELL_W-1:0] clr_addr;
  logic [CELL_W-1:0] cur;
  logic              nb_ok;
  logic [CELL_W-1:0] nb_idx;

  logic [ROW_W-1:0]  cur_r, nb_r;
  logic [COL_W-1:0]  cur_c, nb_c;
  logic              nb_in;
  logic [CELL_W-1:0] nb_cell;
  logic              wall_rd, seen_rd;
  logic [CELL_W-1:0] stack_rd;
  logic              push;

  logic              seen_we, seen_wdata;
  logic [CELL_W-1:0] seen_waddr;
  logic              stack_we;
  logic [CELL_W-1:0] stack_waddr, stack_wdata, stack_raddr;

  assign cur_r = cur[CELL_W-1:COL_W];
  assign cur_c = cur[COL_W-1:0];

  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_in = 1'b0;
    case (cmd.nb_sel)
      NB_RIGHT: begin
        nb_c  = cur_c + 1'b1;
        nb_in = (cur_c != COL_W'(COLS - 1));
      end
      NB_LEFT: begin
        nb_c  = cur_c - 1'b1;
        nb_in = (cur_c != '0);
      end
      NB_DOWN: begin
        nb_r  = cur_r + 1'b1;
        nb_in = (cur_r != ROW_W'(ROWS - 1));
      end
      NB_UP: begin
        nb_r  = cur_r - 1'b1;
        nb_in = (cur_r != '0);
      end
      default: nb_in = 1'b0;
    endcase
  end

  assign nb_cell = {nb_r, nb_c};

  assign push = cmd.nb_eval && nb_ok && !wall_rd && !seen_rd &&
                (count != CNT_W'(NCELLS));

  always_comb begin
    seen_we    = cmd.clr_step || cmd.begin_set || push;
    seen_wdata = !cmd.clr_step;
    if (cmd.clr_step) begin
      seen_waddr = clr_addr;
    end else if (cmd.begin_set) begin
      seen_waddr = start_cell;
    end else begin
      seen_waddr = nb_idx;
    end
  end

  assign stack_we    = cmd.begin_set || push;
  assign stack_waddr = cmd.begin_set ? '0 : count[CELL_W-1:0];
  assign stack_wdata = cmd.begin_set ? start_cell : nb_idx;
  assign stack_raddr = CELL_W'(count - 1'b1);

  gdfs_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_wall_ram (
    .clk   (clk),
    .we    (cmd.wall_we),
    .waddr ({row, col}),
    .wdata (wall),
    .raddr (nb_cell),
    .rdata (wall_rd)
  );

  gdfs_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .raddr (nb_cell),
    .rdata (seen_rd)
  );

  gdfs_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rd)
  );

  assign sts.out_free = !out_valid || out_ready;
  assign sts.empty    = done || (count == '0);
  assign sts.goal     = (stack_rd == goal_cell);
  assign sts.clr_last = (clr_addr == CELL_W'(NCELLS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_cell <= START_RESET;
      goal_cell  <= GOAL_RESET;
      count      <= '0;
      done       <= 1'b1;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_START) begin
        start_cell <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_GOAL) begin
        goal_cell <= cfg_data;
      end
      if (cmd.begin_set) begin
        count <= CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - 1'b1;
      end else if (push) begin
        count <= count + 1'b1;
      end
      if (cmd.begin_set) begin
        done <= 1'b0;
      end else if (cmd.capture && sts.goal) begin
        done <= 1'b1;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.capture || cmd.emit_empty) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur       <= stack_rd;
      visit_row <= stack_rd[CELL_W-1:COL_W];
      visit_col <= stack_rd[COL_W-1:0];
      status    <= sts.goal ? ST_GOAL : ST_CELL;
    end else if (cmd.emit_empty) begin
      visit_row <= '0;
      visit_col <= '0;
      status    <= ST_EMPTY;
    end
    if (cmd.nb_issue) begin
      nb_ok  <= nb_in;
      nb_idx <= nb_cell;
    end
  end

endmodule

// ----- rtl/core/grid_dfs_explorer.sv -----
// ---------------------------------------------------------------------------
// grid_dfs_explorer
// Depth-first explorer over a 16 x 32 grid with 4-neighbor moves and walls.
// ---------------------------------------------------------------------------
// One word is taken at a time. A begin word clears the seen map, which
// lives in a 512-entry RAM, one entry per cycle before the start cell is
// pushed. A step word pops the stack RAM, waits out its read latency, and
// then probes the four neighbors against the wall and seen RAMs, one read
// per cycle with the push decided in the cycle after. A step that reaches
// the goal ends once the popped cell is captured, a step on an empty or
// finished search once the empty result is emitted. A step waits while the
// result register is still full.
module grid_dfs_explorer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [gdfs_pkg::ROW_W-1:0]     row,
  input  logic [gdfs_pkg::COL_W-1:0]     col,
  input  logic                           wall,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gdfs_pkg::ROW_W-1:0]     visit_row,
  output logic [gdfs_pkg::COL_W-1:0]     visit_col,
  output logic [1:0]                     status,
  input  logic                           cfg_we,
  input  logic [gdfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdfs_pkg::CFG_W-1:0]     cfg_data
);
  import gdfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd)
  );

  gdfs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .row       (row),
    .col       (col),
    .wall      (wall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .visit_row (visit_row),
    .visit_col (visit_col),
    .status    (status)
  );

endmodule

// ----- rtl/core/gdfs_monitor.sv -----
// ---------------------------------------------------------------------------
// gdfs_monitor
// Port-level checks for the grid explorer, bound to the top level.
// ---------------------------------------------------------------------------
`include "grid_dfs_explorer_macros.svh"

module gdfs_monitor (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [gdfs_pkg::ROW_W-1:0] visit_row,
  input logic [gdfs_pkg::COL_W-1:0] visit_col,
  input logic [1:0]                 status
);
  import gdfs_pkg::*;

  `GDFS_ASSERT_ANY(a_reset_idle, clk, rst |=> (in_ready && !out_valid), "not idle after reset")

  `GDFS_ASSERT_RST(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(visit_row) && $stable(visit_col)), "result word changed while stalled")

  `GDFS_ASSERT_RST(a_busy_cause, clk, rst, $fell(in_ready) |-> $past(in_valid), "became busy without an input word")

  `GDFS_ASSERT_RST(a_empty_zero, clk, rst, (out_valid && status == ST_EMPTY) |-> (visit_row == '0 && visit_col == '0), "empty result carries a cell")

endmodule

bind grid_dfs_explorer gdfs_monitor u_gdfs_monitor (.*);

// ----- test/grid_dfs_explorer_check.sv -----
// ---------------------------------------------------------------------------
// grid_dfs_explorer_check
// Watches the explorer's channels, predicts every visit and compares.
// ---------------------------------------------------------------------------
// The checker keeps its own wall map, seen map and cell stack. It updates
// them for each accepted input word, queues the visit that a step word
// should produce, and checks each accepted result against the oldest one.
module grid_dfs_explorer_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [gdfs_pkg::ROW_W-1:0]     row,
  input  logic [gdfs_pkg::COL_W-1:0]     col,
  input  logic                           wall,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [gdfs_pkg::ROW_W-1:0]     visit_row,
  input  logic [gdfs_pkg::COL_W-1:0]     visit_col,
  input  logic [1:0]                     status,
  input  logic                           cfg_we,
  input  logic [gdfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gdfs_pkg::CFG_W-1:0]     cfg_data,
  output int                             errors,
  output int                             pending
);
  import gdfs_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] vrow;
    logic [COL_W-1:0] vcol;
    logic [1:0]       st;
  } visit_t;

  bit                wall_bits [NCELLS];
  bit                seen_bits [NCELLS];
  logic [CELL_W-1:0] dfs_stack [NCELLS];
  int unsigned       depth;
  bit                finished;
  logic [CELL_W-1:0] start_reg;
  logic [CELL_W-1:0] goal_reg;
  visit_t            visits_due[$];
  visit_t            due;
  int                fail_count = 0;

  assign errors = fail_count;

  function automatic void queue_visit(logic [ROW_W-1:0] vr, logic [COL_W-1:0] vc,
                                      logic [1:0] st);
    visit_t v;
    v.vrow = vr;
    v.vcol = vc;
    v.st   = st;
    visits_due.insert(visits_due.size(), v);
  endfunction

  function automatic void push_neighbor(int r, int c);
    int idx;
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return;
    idx = r * COLS + c;
    if (wall_bits[idx] || seen_bits[idx] || depth >= NCELLS) return;
    seen_bits[idx] = 1'b1;
    dfs_stack[depth] = CELL_W'(idx);
    depth++;
  endfunction

  function automatic void explore_word(logic [1:0] op, logic [ROW_W-1:0] r,
                                       logic [COL_W-1:0] c, logic w);
    logic [CELL_W-1:0] cur;
    int                cr;
    int                cc;
    case (op)
      OP_WALL: begin
        wall_bits[{r, c}] = w;
      end
      OP_BEGIN: begin
        foreach (seen_bits[i]) seen_bits[i] = 1'b0;
        seen_bits[start_reg] = 1'b1;
        dfs_stack[0] = start_reg;
        depth = 1;
        finished = 1'b0;
      end
      OP_STEP: begin
        if (finished || depth == 0) begin
          queue_visit('0, '0, ST_EMPTY);
        end else begin
          depth--;
          cur = dfs_stack[depth];
          cr = int'(cur) / COLS;
          cc = int'(cur) % COLS;
          if (cur == goal_reg) begin
            finished = 1'b1;
            queue_visit(ROW_W'(cr), COL_W'(cc), ST_GOAL);
          end else begin
            queue_visit(ROW_W'(cr), COL_W'(cc), ST_CELL);
            push_neighbor(cr, cc + 1);
            push_neighbor(cr, cc - 1);
            push_neighbor(cr + 1, cc);
            push_neighbor(cr - 1, cc);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (wall_bits[i]) wall_bits[i] = 1'b0;
      foreach (seen_bits[i]) seen_bits[i] = 1'b0;
      depth = 0;
      finished = 1'b1;
      start_reg = START_RESET;
      goal_reg = GOAL_RESET;
      visits_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_START) start_reg = cfg_data;
        if (cfg_index == REG_GOAL) goal_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (visits_due.size() == 0) begin
          $display("%0t: unexpected word: row %0d col %0d status %0d",
                   $time, visit_row, visit_col, status);
          fail_count++;
        end else begin
          due = visits_due.pop_front();
          if (visit_row !== due.vrow) begin
            $display("%0t: visit_row expected %0d, got %0d", $time, due.vrow, visit_row);
            fail_count++;
          end
          if (visit_col !== due.vcol) begin
            $display("%0t: visit_col expected %0d, got %0d", $time, due.vcol, visit_col);
            fail_count++;
          end
          if (status !== due.st) begin
            $display("%0t: status expected %0d, got %0d", $time, due.st, status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) explore_word(operation, row, col, wall);
    end
    pending <= visits_due.size();
  end

endmodule

// ----- test/grid_dfs_explorer_test.sv -----
// ---------------------------------------------------------------------------
// grid_dfs_explorer_test
// Stimulus and verdict for the grid depth-first explorer.
// ---------------------------------------------------------------------------
// The whole wall map is written first, then a short directed run covers the
// corner cells, an enclosed start on a wall, steps with no search, a goal
// equal to the start and the spare operation code. Random phases follow,
// each with new start and goal cells and one to three searches, with random
// gaps on both channels outside a calm stretch. The checker beside the block does the comparing.
module grid_dfs_explorer_test;
  import gdfs_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 600;
  localparam int RANDOM_WORDS = 740;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           operation = OP_WALL;
  logic [ROW_W-1:0]     row = '0;
  logic [COL_W-1:0]     col = '0;
  logic                 wall = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ROW_W-1:0]     visit_row;
  logic [COL_W-1:0]     visit_col;
  logic [1:0]           status;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_START;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   errors;
  int                   pending;
  bit                   calm = 1'b0;
  int                   words_sent = 0;
  int                   searches = 0;
  int                   settings = 0;

  grid_dfs_explorer u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .row(row), .col(col), .wall(wall),
    .out_valid(out_valid), .out_ready(out_ready),
    .visit_row(visit_row), .visit_col(visit_col), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  grid_dfs_explorer_check u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .row(row), .col(col), .wall(wall),
    .out_valid(out_valid), .out_ready(out_ready),
    .visit_row(visit_row), .visit_col(visit_col), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 29);
  end

  task automatic send_word(input logic [1:0] op, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c, input logic w);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    row <= r;
    col <= c;
    wall <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_random(input logic [1:0] op);
    send_word(op, ROW_W'($urandom_range(0, ROWS - 1)), COL_W'($urandom_range(0, COLS - 1)),
              1'($urandom_range(0, 1)));
  endtask

  // Hold the sender until every visit is back and a begin has had time to finish.
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_search(input logic [CELL_W-1:0] s, input logic [CELL_W-1:0] g);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_START;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= REG_GOAL;
    cfg_data <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    int base;
    int n;
    int pick;
    logic [CELL_W-1:0] s;
    logic [CELL_W-1:0] g;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        send_word(OP_WALL, ROW_W'(r), COL_W'(c), 1'($urandom_range(0, 99) < 25));
      end
    end

    send_word(OP_SPARE, 4'd15, 5'd31, 1'b1);
    send_random(OP_STEP);
    send_word(OP_WALL, 4'd0, 5'd0, 1'b1);
    send_word(OP_WALL, 4'd0, 5'd1, 1'b1);
    send_word(OP_WALL, 4'd1, 5'd0, 1'b1);
    send_random(OP_BEGIN);
    send_random(OP_STEP);
    send_random(OP_STEP);
    send_word(OP_WALL, 4'd15, 5'd30, 1'b0);
    send_word(OP_WALL, 4'd14, 5'd31, 1'b0);
    send_word(OP_WALL, 4'd15, 5'd29, 1'b0);
    set_search(CELL_W'(511), CELL_W'(510));
    send_random(OP_BEGIN);
    repeat (4) send_random(OP_STEP);
    set_search(CELL_W'(511), CELL_W'(511));
    send_random(OP_BEGIN);
    send_random(OP_STEP);
    send_random(OP_STEP);
    searches += 3;

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      s = CELL_W'($urandom_range(0, NCELLS - 1));
      g = CELL_W'($urandom_range(0, NCELLS - 1));
      if (pick == 0) begin
        s = '0;
        g = CELL_W'(NCELLS - 1);
      end else if (pick == 1) begin
        s = CELL_W'(NCELLS - 1);
        g = '0;
      end else if (pick == 2) begin
        g = s;
      end else if (pick < 7) begin
        g = s + CELL_W'($urandom_range(1, 40));
      end
      set_search(s, g);
      repeat ($urandom_range(1, 3)) begin
        send_random(OP_BEGIN);
        searches++;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(4, 40);
        repeat (n) begin
          calm = (words_sent - base >= 300) && (words_sent - base < 450);
          pick = $urandom_range(0, 99);
          if (pick < 4) begin
            send_word(OP_WALL, ROW_W'($urandom_range(0, ROWS - 1)),
                      COL_W'($urandom_range(0, COLS - 1)), 1'($urandom_range(0, 99) < 25));
          end else if (pick < 6) begin
            send_random(OP_SPARE);
          end else if (pick < 8) begin
            send_random(OP_BEGIN);
          end else begin
            send_random(OP_STEP);
          end
        end
      end
    end
    calm = 1'b0;

    drain_results();
    $display("Sent %0d words: %0d searches under %0d start and goal settings,",
             words_sent, searches, settings);
    $display("with wall rewrites, spare codes and steps past the end of a search.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d visits outstanding.", pending);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
